>>> design/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

    // Screen geometry
    localparam int COLUMNS       = 80;
    localparam int ROWS          = 25;
    localparam int CELL_COUNT    = ROWS * COLUMNS;
    localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;

    localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int POS_W = $clog2(CELL_COUNT);

    // Port field widths
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int IDX_W    = 11;
    localparam int CURPOS_W = 11;
    localparam int CELL_W   = 16;

    // Width of a linear index before it is folded onto the ring of rows
    localparam int SUM_W = ((POS_W > IDX_W) ? POS_W : IDX_W) + 1;

    // Codes
    localparam logic             OP_PUT         = 1'b0;
    localparam logic             OP_READ        = 1'b1;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] GLYPH_BLANK    = 8'h20;
    localparam logic [ATTR_W-1:0] ATTR_RESET     = 8'h07;
    localparam logic [CELL_W-1:0] RESET_CELL     = 16'h0720;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_BLANK
    } ctrl_state_t;

    typedef struct packed {
        logic                we;
        logic [POS_W-1:0]    waddr;
        logic [CELL_W-1:0]   wdata;
        logic                re;
        logic [POS_W-1:0]    raddr;
    } mem_req_t;

    typedef struct packed {
        logic                valid;
        logic [CELL_W-1:0]   cell_value;
        logic [POS_W-1:0]    cursor_pos;
        logic                scrolled;
    } result_t;

    function automatic logic [CELL_W-1:0] make_cell(
        input logic [CHAR_W-1:0] glyph,
        input logic [ATTR_W-1:0] attr
    );
        return {attr, glyph};
    endfunction

    // Map a logical cell index onto the store; the top row sits at base.
    function automatic logic [POS_W-1:0] phys_addr(
        input logic [SUM_W-1:0] lin,
        input logic [POS_W-1:0] base
    );
        logic [SUM_W-1:0] sum;
        sum = lin + SUM_W'(base);
        if (sum >= SUM_W'(CELL_COUNT))
        begin
            sum = sum - SUM_W'(CELL_COUNT);
        end
        return sum[POS_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> design/tcw_ram.sv
`default_nettype none

module tcw_ram #(
    parameter int DEPTH  = 2048,
    parameter int WIDTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> design/tcw_ctrl.sv
`default_nettype none

module tcw_ctrl
    import tcw_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              in_opcode,
    input  wire logic [CHAR_W-1:0] in_char,
    input  wire logic [IDX_W-1:0]  in_index,
    input  wire logic [ATTR_W-1:0] attr,
    input  wire logic              out_free,
    input  wire logic [CELL_W-1:0] mem_rdata,
    output mem_req_t               mem_req,
    output result_t                result
);

    ctrl_state_t       state_reg, state_next;
    logic [POS_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [COL_W-1:0]  blank_cnt_reg, blank_cnt_next;
    logic [ATTR_W-1:0] blank_attr_reg, blank_attr_next;
    logic [POS_W-1:0]  base_reg, base_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [POS_W-1:0]  pos_reg, pos_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            blank_cnt_reg  <= '0;
            blank_attr_reg <= ATTR_RESET;
            base_reg       <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            pos_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            blank_cnt_reg  <= blank_cnt_next;
            blank_attr_reg <= blank_attr_next;
            base_reg       <= base_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            pos_reg        <= pos_next;
        end
    end

    always_comb
    begin
        logic at_last_row;
        logic at_last_col;
        logic [SUM_W-1:0] idx_ext;

        at_last_row = (row_reg == ROW_W'(ROWS - 1));
        at_last_col = (col_reg == COL_W'(COLUMNS - 1));
        idx_ext     = SUM_W'(in_index);

        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        blank_cnt_next  = blank_cnt_reg;
        blank_attr_next = blank_attr_reg;
        base_next       = base_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        pos_next        = pos_reg;

        in_ready          = 1'b0;
        mem_req           = '0;
        result            = '0;
        result.cursor_pos = pos_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = clr_cnt_reg;
                mem_req.wdata = RESET_CELL;
                if (clr_cnt_reg == POS_W'(CELL_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                in_ready = out_free;
                if (in_valid && out_free)
                begin
                    case (in_opcode)
                        OP_READ:
                        begin
                            if (idx_ext < SUM_W'(CELL_COUNT))
                            begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = phys_addr(idx_ext, base_reg);
                                state_next    = ST_READ;
                            end
                            else
                            begin
                                result.valid = 1'b1;
                            end
                        end

                        OP_PUT:
                        begin
                            result.valid = 1'b1;
                            case (in_char)
                                CHAR_NEWLINE:
                                begin
                                    col_next = '0;
                                    if (at_last_row)
                                    begin
                                        pos_next        = POS_W'(LAST_ROW_BASE);
                                        result.scrolled = 1'b1;
                                    end
                                    else
                                    begin
                                        row_next = row_reg + 1'b1;
                                        pos_next = pos_reg - POS_W'(col_reg) + POS_W'(COLUMNS);
                                    end
                                end

                                CHAR_BACKSPACE:
                                begin
                                    if (col_reg != '0)
                                    begin
                                        col_next = col_reg - 1'b1;
                                        pos_next = pos_reg - 1'b1;
                                    end
                                    else if (row_reg != '0)
                                    begin
                                        row_next = row_reg - 1'b1;
                                        col_next = COL_W'(COLUMNS - 1);
                                        pos_next = pos_reg - 1'b1;
                                    end
                                    mem_req.we    = 1'b1;
                                    mem_req.waddr = phys_addr(SUM_W'(pos_next), base_reg);
                                    mem_req.wdata = make_cell(GLYPH_BLANK, attr);
                                    result.cell_value = mem_req.wdata;
                                end

                                default:
                                begin
                                    mem_req.we    = 1'b1;
                                    mem_req.waddr = phys_addr(SUM_W'(pos_reg), base_reg);
                                    mem_req.wdata = make_cell(in_char, attr);
                                    result.cell_value = mem_req.wdata;
                                    if (at_last_col)
                                    begin
                                        col_next = '0;
                                        if (at_last_row)
                                        begin
                                            pos_next        = POS_W'(LAST_ROW_BASE);
                                            result.scrolled = 1'b1;
                                        end
                                        else
                                        begin
                                            row_next = row_reg + 1'b1;
                                            pos_next = pos_reg + 1'b1;
                                        end
                                    end
                                    else
                                    begin
                                        col_next = col_reg + 1'b1;
                                        pos_next = pos_reg + 1'b1;
                                    end
                                end
                            endcase
                            if (result.scrolled)
                            begin
                                // Hold the attribute of the scrolling word for the blank row
                                blank_attr_next = attr;
                                blank_cnt_next  = '0;
                                state_next      = ST_BLANK;
                            end
                        end

                        default:
                        begin
                            result.valid = 1'b0;
                        end
                    endcase
                    result.cursor_pos = pos_next;
                end
            end

            ST_READ:
            begin
                if (out_free)
                begin
                    result.valid      = 1'b1;
                    result.cell_value = mem_rdata;
                    state_next        = ST_IDLE;
                end
            end

            ST_BLANK:
            begin
                // The old top row becomes the new bottom row
                mem_req.we    = 1'b1;
                mem_req.waddr = base_reg + POS_W'(blank_cnt_reg);
                mem_req.wdata = make_cell(GLYPH_BLANK, blank_attr_reg);
                if (blank_cnt_reg == COL_W'(COLUMNS - 1))
                begin
                    if (base_reg == POS_W'(LAST_ROW_BASE))
                    begin
                        base_next = '0;
                    end
                    else
                    begin
                        base_next = base_reg + POS_W'(COLUMNS);
                    end
                    state_next = ST_IDLE;
                end
                else
                begin
                    blank_cnt_next = blank_cnt_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/text_console_writer.sv
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tdata: char_code, cell_index; s_tuser: opcode
// m_        out  m_tvalid/m_tready  m_tdata: cell_value, cursor_pos, scrolled
// cfg_      in   cfg_valid/cfg_ready cfg_data: text_attribute
//
// A put of a newline, a backspace or any other byte is answered from the idle
// state; a read of a cell in range waits in the READ state for the registered
// read data of the cell store. A put that scrolls then blanks the new bottom row
// in the BLANK state; rows rotate through a base pointer, so no cells are copied.
// After reset a clearing pass writes every cell, with s_tready low. A result
// waits in the output register while m_tready is low and the next word is
// taken once that register drains.
`default_nettype none

module text_console_writer
    import tcw_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [7:0] char_code, [18:8] cell_index, [23:19] zero
    input  wire logic        s_tuser,   // [0] opcode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // [15:0] cell_value, [26:16] cursor_pos, [27] scrolled
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data
);

    logic [ATTR_W-1:0]   attr_reg;
    logic                out_valid_reg;
    logic [CELL_W-1:0]   out_value_reg;
    logic [CURPOS_W-1:0] out_pos_reg;
    logic                out_scrolled_reg;
    logic                out_free;
    logic [CELL_W-1:0]   mem_rdata;
    mem_req_t            mem_req;
    result_t             result;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= ATTR_RESET;
        end
        else if (cfg_valid)
        begin
            attr_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= result.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.valid)
        begin
            out_value_reg    <= result.cell_value;
            out_pos_reg      <= CURPOS_W'(result.cursor_pos);
            out_scrolled_reg <= result.scrolled;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_scrolled_reg, out_pos_reg, out_value_reg};

    tcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_opcode (s_tuser),
        .in_char   (s_tdata[7:0]),
        .in_index  (s_tdata[18:8]),
        .attr      (attr_reg),
        .out_free  (out_free),
        .mem_rdata (mem_rdata),
        .mem_req   (mem_req),
        .result    (result)
    );

    tcw_ram #(
        .DEPTH  (CELL_COUNT),
        .WIDTH  (CELL_W),
        .ADDR_W (POS_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;
    import tcw_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    // a scroll keeps blanking the bottom row after its word has left
    localparam int SETTLE_CYCLES = 2 * COLUMNS + 16;
    localparam int PHASE_ITEMS   = 250;

    class console_mirror;
        logic [CELL_W-1:0] cells [CELL_COUNT];
        int unsigned       row;
        int unsigned       col;
        logic [ATTR_W-1:0] attr;
        logic [31:0]       expected_words [$];
        int unsigned       mismatches;

        function new();
            foreach (cells[i])
                cells[i] = RESET_CELL;
            row = 0;
            col = 0;
            attr = ATTR_RESET;
            mismatches = 0;
        endfunction

        function int unsigned cursor_lin();
            return row * COLUMNS + col;
        endfunction

        // step down one row; scroll up and blank the bottom row past the last one
        function logic next_line();
            row++;
            if (row < ROWS)
                return 1'b0;
            for (int i = 0; i < CELL_COUNT - COLUMNS; i++)
                cells[i] = cells[i + COLUMNS];
            for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
                cells[i] = {attr, GLYPH_BLANK};
            row = ROWS - 1;
            return 1'b1;
        endfunction

        function void apply_item(logic op, logic [CHAR_W-1:0] ch, logic [IDX_W-1:0] idx);
            logic [CELL_W-1:0] value;
            logic              rolled;
            int unsigned       lin;
            value = '0;
            rolled = 1'b0;
            if (op == OP_READ)
            begin
                if (idx < CELL_COUNT)
                    value = cells[idx];
            end
            else if (ch == CHAR_NEWLINE)
            begin
                col = 0;
                rolled = next_line();
            end
            else if (ch == CHAR_BACKSPACE)
            begin
                if (col > 0)
                    col--;
                else if (row > 0)
                begin
                    row--;
                    col = COLUMNS - 1;
                end
                value = {attr, GLYPH_BLANK};
                cells[row * COLUMNS + col] = value;
            end
            else
            begin
                value = {attr, ch};
                cells[row * COLUMNS + col] = value;
                col++;
                if (col >= COLUMNS)
                begin
                    col = 0;
                    rolled = next_line();
                end
            end
            lin = cursor_lin();
            expected_words.push_back({4'b0, rolled, lin[CURPOS_W-1:0], value});
        endfunction

        function void compare_word(logic [31:0] word);
            logic [31:0] want;
            logic        bad;
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word %h", word);
                return;
            end
            want = expected_words.pop_front();
            bad = (word[15:0] !== want[15:0]) || (word[26:16] !== want[26:16])
                || (word[27] !== want[27]);
            if (bad)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: cell %h/%h pos %0d/%0d scrolled %b/%b (exp/got)",
                        want[15:0], word[15:0], want[26:16], word[26:16], want[27], word[27]);
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [23:0]       s_tdata = '0;
    logic              s_tuser = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [31:0]       m_tdata;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [ATTR_W-1:0] cfg_data = '0;

    console_mirror mirror = new();
    bit            gaps_on = 1'b1;
    bit            driving = 1'b0;
    int            stall_left = 0;

    always #4 clk = ~clk;

    text_console_writer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // check accepted words, then pick next cycle's ready
    always @(posedge clk)
    begin
        int r;
        if (rst_n && m_tvalid && m_tready)
            mirror.compare_word(m_tdata);
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end
        else if (!gaps_on)
            m_tready <= 1'b1;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
                m_tready <= 1'b1;
            else
            begin
                stall_left = (r < 97) ? $urandom_range(0, 2) : $urandom_range(10, 40);
                m_tready <= 1'b0;
            end
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb: FAIL");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 4);
        return $urandom_range(15, 60);
    endfunction

    task automatic send_item(input logic op, input logic [CHAR_W-1:0] ch,
                             input logic [IDX_W-1:0] idx);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            if (driving)
                s_tvalid <= 1'b0;
            driving = 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'b0, idx, ch};
        s_tuser <= op;
        driving = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        mirror.apply_item(op, ch, idx);
    endtask

    task automatic put_char(input logic [CHAR_W-1:0] ch);
        send_item(OP_PUT, ch, IDX_W'($urandom_range(0, 2047)));
    endtask

    task automatic read_cell(input int unsigned idx);
        send_item(OP_READ, CHAR_W'($urandom_range(0, 255)), IDX_W'(idx));
    endtask

    // hold the sender until every word is back and the block is quiet
    task automatic drain();
        if (driving)
            s_tvalid <= 1'b0;
        driving = 1'b0;
        while (mirror.expected_words.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_attribute(input logic [ATTR_W-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        mirror.attr = value;
    endtask

    task automatic run_phase(input int unsigned budget);
        int unsigned sent;
        int unsigned n;
        int unsigned back;
        int          r;
        int          k;
        sent = 0;
        while (sent < budget)
        begin
            r = $urandom_range(0, 99);
            if (r < 35)
            begin
                n = $urandom_range(1, 100);
                for (int i = 0; i < n; i++)
                begin
                    if ($urandom_range(0, 4) != 0)
                        put_char(CHAR_W'($urandom_range(8'h20, 8'h7E)));
                    else
                        put_char(CHAR_W'($urandom_range(0, 255)));
                end
            end
            else if (r < 50)
            begin
                n = $urandom_range(1, 30);
                repeat (n) put_char(CHAR_NEWLINE);
            end
            else if (r < 60)
            begin
                n = $urandom_range(1, 90);
                repeat (n) put_char(CHAR_BACKSPACE);
            end
            else if (r < 80)
            begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                begin
                    k = $urandom_range(0, 99);
                    back = $urandom_range(0, 5);
                    if (k < 50)
                        read_cell((mirror.cursor_lin() > back) ?
                            mirror.cursor_lin() - back : 0);
                    else if (k < 85)
                        read_cell($urandom_range(0, CELL_COUNT - 1));
                    else
                        read_cell($urandom_range(CELL_COUNT, 2047));
                end
            end
            else
            begin
                n = $urandom_range(1, 10);
                repeat (n)
                    send_item(1'($urandom_range(0, 1)), CHAR_W'($urandom_range(0, 255)),
                        IDX_W'($urandom_range(0, 2047)));
            end
            sent += n;
            if ($urandom_range(0, 49) == 0)
                drain();
        end
    endtask

    initial
    begin
        logic [ATTR_W-1:0] attrs [5];
        attrs[0] = 8'h00;
        attrs[1] = 8'hFF;
        attrs[2] = ATTR_W'($urandom_range(0, 255));
        attrs[3] = ATTR_W'($urandom_range(0, 255));
        attrs[4] = ATTR_RESET;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset contents, range edges, control bytes at the corners
        read_cell(0);
        read_cell(CELL_COUNT - 1);
        read_cell(CELL_COUNT);
        read_cell(2047);
        read_cell(1024);
        put_char(CHAR_BACKSPACE);
        put_char(8'h00);
        put_char(8'hFF);
        put_char(8'h41);
        put_char(8'h7F);
        put_char(8'h80);
        put_char(CHAR_NEWLINE);
        put_char(CHAR_BACKSPACE);
        read_cell(COLUMNS - 1);
        put_char(8'h5A);
        read_cell(1);
        read_cell(2);
        read_cell(COLUMNS - 1);
        put_char(CHAR_BACKSPACE);
        put_char(CHAR_BACKSPACE);
        read_cell(0);
        drain();

        foreach (attrs[p])
        begin
            write_attribute(attrs[p]);
            gaps_on = (p != 1);
            run_phase(PHASE_ITEMS);
        end

        drain();
        if (mirror.mismatches == 0 && mirror.expected_words.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
